// ===== src/ittf_pkg.sv =====
// ittf_pkg: shared types and constants for the integer-to-text formatter.
// Used by ittf_conv, ittf_emit and integer_to_text_formatter; no dependencies.
package ittf_pkg;

  localparam int NUM_DIGITS = 24;
  localparam int DIG_W      = 4;
  localparam int DIGS_W     = NUM_DIGITS * DIG_W;
  localparam int ND_W       = 5;
  localparam int VAL_W      = 64;

  localparam logic [2:0] MODE_D     = 3'd0;
  localparam logic [2:0] MODE_O     = 3'd1;
  localparam logic [2:0] MODE_U     = 3'd2;
  localparam logic [2:0] MODE_X_LO  = 3'd3;
  localparam logic [2:0] MODE_X_UP  = 3'd4;
  localparam logic [2:0] MODE_P     = 3'd5;

  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef enum logic [1:0] {BASE_8, BASE_10, BASE_16} base_t;

  typedef enum logic [1:0] {CV_IDLE, CV_DABBLE, CV_SCAN, CV_HOLD} conv_state_t;

  typedef enum logic [1:0] {EM_IDLE, EM_WAIT, EM_RUN} emit_state_t;

  typedef struct packed {
    logic [15:0] pre;
    logic [1:0]  np;
    logic        ucase;
    logic        lal;
    logic        zpad;
    logic [6:0]  width;
  } job_t;

  typedef struct packed {
    logic             done;
    logic [ND_W-1:0]  nd;
    logic [DIG_W-1:0] top;
  } conv_status_t;

endpackage

// ===== src/ittf_conv.sv =====
// ittf_conv: radix conversion of a 64-bit magnitude into a digit shift register.
// Decimal goes bit-serial through double-dabble; leading zeros are stripped
// one digit per cycle. Depends on ittf_pkg.
module ittf_conv (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ittf_pkg::VAL_W-1:0]          mag,
  input  ittf_pkg::base_t                     base,
  input  logic                                pop,
  output ittf_pkg::conv_status_t              status
);

  localparam int CNT_W = $clog2(ittf_pkg::VAL_W);

  ittf_pkg::conv_state_t state_r, state_nxt;
  logic [ittf_pkg::DIGS_W-1:0] dig_r, dig_nxt;
  logic [ittf_pkg::VAL_W-1:0]  mag_r, mag_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [ittf_pkg::ND_W-1:0]   nd_r, nd_nxt;
  logic [ittf_pkg::DIGS_W-1:0] adj;
  logic [ittf_pkg::DIGS_W-1:0] load_dig;
  logic [ittf_pkg::VAL_W+1:0]  mag_ext;
  logic [ittf_pkg::DIG_W-1:0]  top;

  assign top     = dig_r[ittf_pkg::DIGS_W-1 -: ittf_pkg::DIG_W];
  assign mag_ext = {2'b00, mag};

  always_comb begin
    load_dig = '0;
    if (base == ittf_pkg::BASE_16) begin
      load_dig[ittf_pkg::VAL_W-1:0] = mag;
    end else begin
      for (int i = 0; i < (ittf_pkg::VAL_W + 2) / 3; i++) begin
        load_dig[i*ittf_pkg::DIG_W +: ittf_pkg::DIG_W] = {1'b0, mag_ext[i*3 +: 3]};
      end
    end
  end

  // add-3 correction, every BCD digit independent
  always_comb begin
    for (int i = 0; i < ittf_pkg::NUM_DIGITS; i++) begin
      if (dig_r[i*ittf_pkg::DIG_W +: ittf_pkg::DIG_W] >= 4'd5) begin
        adj[i*ittf_pkg::DIG_W +: ittf_pkg::DIG_W] =
          dig_r[i*ittf_pkg::DIG_W +: ittf_pkg::DIG_W] + 4'd3;
      end else begin
        adj[i*ittf_pkg::DIG_W +: ittf_pkg::DIG_W] =
          dig_r[i*ittf_pkg::DIG_W +: ittf_pkg::DIG_W];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    mag_nxt   = mag_r;
    cnt_nxt   = cnt_r;
    nd_nxt    = nd_r;
    if (start) begin
      mag_nxt = mag;
      cnt_nxt = '1;
      nd_nxt  = ittf_pkg::ND_W'(ittf_pkg::NUM_DIGITS);
      if (base == ittf_pkg::BASE_10) begin
        dig_nxt   = '0;
        state_nxt = ittf_pkg::CV_DABBLE;
      end else begin
        dig_nxt   = load_dig;
        state_nxt = ittf_pkg::CV_SCAN;
      end
    end else begin
      unique case (state_r)
        ittf_pkg::CV_IDLE: begin
        end
        ittf_pkg::CV_DABBLE: begin
          dig_nxt = {adj[ittf_pkg::DIGS_W-2:0], mag_r[ittf_pkg::VAL_W-1]};
          mag_nxt = {mag_r[ittf_pkg::VAL_W-2:0], 1'b0};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_nxt = ittf_pkg::CV_SCAN;
          end
        end
        ittf_pkg::CV_SCAN: begin
          if (top == '0 && nd_r > ittf_pkg::ND_W'(1)) begin
            dig_nxt = {dig_r[ittf_pkg::DIGS_W-ittf_pkg::DIG_W-1:0], {ittf_pkg::DIG_W{1'b0}}};
            nd_nxt  = nd_r - 1'b1;
          end else begin
            state_nxt = ittf_pkg::CV_HOLD;
          end
        end
        ittf_pkg::CV_HOLD: begin
          if (pop) begin
            dig_nxt = {dig_r[ittf_pkg::DIGS_W-ittf_pkg::DIG_W-1:0], {ittf_pkg::DIG_W{1'b0}}};
          end
        end
        default: state_nxt = ittf_pkg::CV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ittf_pkg::CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    mag_r <= mag_nxt;
    cnt_r <= cnt_nxt;
    nd_r  <= nd_nxt;
  end

  assign status.done = (state_r == ittf_pkg::CV_HOLD);
  assign status.nd   = nd_r;
  assign status.top  = top;

endmodule

// ===== src/ittf_emit.sv =====
// ittf_emit: character sequencer and output register. Emits padding, sign or
// prefix and digits one character per cycle while out_ready allows. Depends on ittf_pkg.
module ittf_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  ittf_pkg::job_t         job,
  input  ittf_pkg::conv_status_t conv_st,
  output logic                   pop,
  output logic                   idle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_char,
  output logic                   out_last
);

  ittf_pkg::emit_state_t state_r, state_nxt;
  ittf_pkg::job_t        job_r, job_nxt;
  logic [6:0] lpad_r, lpad_nxt, zpad_r, zpad_nxt, rpad_r, rpad_nxt, rem_r, rem_nxt;
  logic [ittf_pkg::ND_W-1:0] nd_r, nd_nxt;
  logic       out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic [6:0] len, pad;
  logic [7:0] dig_char;
  logic       load;

  assign len  = 7'(job_r.np) + 7'(conv_st.nd);
  assign pad  = (job_r.width > len) ? (job_r.width - len) : 7'd0;
  assign load = !out_valid_r || out_ready;

  always_comb begin
    if (conv_st.top < 4'd10) begin
      dig_char = ittf_pkg::CH_ZERO + 8'(conv_st.top);
    end else if (job_r.ucase) begin
      dig_char = ittf_pkg::CH_A_UP + 8'(conv_st.top - 4'd10);
    end else begin
      dig_char = ittf_pkg::CH_A_LO + 8'(conv_st.top - 4'd10);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    lpad_nxt      = lpad_r;
    zpad_nxt      = zpad_r;
    rpad_nxt      = rpad_r;
    rem_nxt       = rem_r;
    nd_nxt        = nd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    unique case (state_r)
      ittf_pkg::EM_IDLE: begin
        if (start) begin
          job_nxt   = job;
          state_nxt = ittf_pkg::EM_WAIT;
        end
      end
      ittf_pkg::EM_WAIT: begin
        if (conv_st.done) begin
          nd_nxt    = conv_st.nd;
          lpad_nxt  = (!job_r.lal && !job_r.zpad) ? pad : 7'd0;
          zpad_nxt  = (!job_r.lal && job_r.zpad) ? pad : 7'd0;
          rpad_nxt  = job_r.lal ? pad : 7'd0;
          rem_nxt   = len + pad;
          state_nxt = ittf_pkg::EM_RUN;
        end
      end
      ittf_pkg::EM_RUN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (rem_r == 7'd1);
          rem_nxt       = rem_r - 1'b1;
          if (lpad_r != '0) begin
            out_char_nxt = ittf_pkg::CH_SPACE;
            lpad_nxt     = lpad_r - 1'b1;
          end else if (job_r.np != '0) begin
            out_char_nxt = job_r.pre[15:8];
            job_nxt.pre  = {job_r.pre[7:0], 8'h00};
            job_nxt.np   = job_r.np - 1'b1;
          end else if (zpad_r != '0) begin
            out_char_nxt = ittf_pkg::CH_ZERO;
            zpad_nxt     = zpad_r - 1'b1;
          end else if (nd_r != '0) begin
            out_char_nxt = dig_char;
            nd_nxt       = nd_r - 1'b1;
            pop          = 1'b1;
          end else begin
            out_char_nxt = ittf_pkg::CH_SPACE;
            rpad_nxt     = rpad_r - 1'b1;
          end
          if (rem_r == 7'd1) begin
            state_nxt = ittf_pkg::EM_IDLE;
          end
        end
      end
      default: state_nxt = ittf_pkg::EM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ittf_pkg::EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    lpad_r     <= lpad_nxt;
    zpad_r     <= zpad_nxt;
    rpad_r     <= rpad_nxt;
    rem_r      <= rem_nxt;
    nd_r       <= nd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign idle      = (state_r == ittf_pkg::EM_IDLE);
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// ===== src/integer_to_text_formatter.sv =====
// integer_to_text_formatter: top level of the printf-style integer formatter.
// Instantiates ittf_conv and ittf_emit; depends on ittf_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one number with its conversion
//   code and flags. Result channel (out_valid/out_ready) returns the text,
//   one ASCII character per item, out_last high on the final character.
//   Invalid conversion codes (6, 7) are taken and produce no characters.
// Flow:
//   Decimal conversions run a bit-serial double-dabble; octal and hex
//   load their digits directly. Leading-zero stripping then removes one
//   leading zero digit per cycle (up to 23). Characters leave at one per
//   cycle while out_ready allows, up to max(field width, 23) of them.
//   in_ready rises again once the final character sits in the output
//   register, so the next number converts while it waits.
// Reset: synchronous, active low; clears the sequencers and output valid.
// Stall: with out_ready low the output register holds and emission waits.
module integer_to_text_formatter #(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  input  logic [2:0]  in_mode,
  input  logic        in_wide64,
  input  logic        in_alt_form,
  input  logic        in_zero_pad,
  input  logic        in_left_align,
  input  logic [1:0]  in_sign_mode,
  input  logic [6:0]  in_field_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last
);

  localparam logic [6:0] MaxW = 7'(MAX_WIDTH);

  logic                   accept, start, pop, emit_idle, mag_zero, neg;
  logic [63:0]            sval, mag;
  ittf_pkg::base_t        base;
  ittf_pkg::job_t         job;
  ittf_pkg::conv_status_t conv_st;

  assign accept = in_valid && in_ready;
  assign start  = accept && (in_mode <= ittf_pkg::MODE_P);

  always_comb begin
    unique case (in_mode)
      ittf_pkg::MODE_O:                   base = ittf_pkg::BASE_8;
      ittf_pkg::MODE_D, ittf_pkg::MODE_U: base = ittf_pkg::BASE_10;
      default:                            base = ittf_pkg::BASE_16;
    endcase
  end

  always_comb begin
    sval     = in_wide64 ? in_value : {{32{in_value[31]}}, in_value[31:0]};
    neg      = sval[63];
    job      = '0;
    job.ucase = (in_mode == ittf_pkg::MODE_X_UP);
    job.lal   = in_left_align;
    job.zpad  = in_zero_pad;
    job.width = (in_field_width > MaxW) ? MaxW : in_field_width;
    if (in_mode == ittf_pkg::MODE_D) begin
      mag = neg ? (64'd0 - sval) : sval;
    end else begin
      mag = in_wide64 ? in_value : {32'd0, in_value[31:0]};
    end
    mag_zero = (mag == '0);
    if (in_mode == ittf_pkg::MODE_D) begin
      if (neg) begin
        job.pre = {ittf_pkg::CH_MINUS, 8'h00};
        job.np  = 2'd1;
      end else if (in_sign_mode == ittf_pkg::SIGN_PLUS) begin
        job.pre = {ittf_pkg::CH_PLUS, 8'h00};
        job.np  = 2'd1;
      end else if (in_sign_mode == ittf_pkg::SIGN_SPACE) begin
        job.pre = {ittf_pkg::CH_SPACE, 8'h00};
        job.np  = 2'd1;
      end
    end else if (in_mode == ittf_pkg::MODE_P || in_alt_form) begin
      if (base == ittf_pkg::BASE_8 && !mag_zero) begin
        job.pre = {ittf_pkg::CH_ZERO, 8'h00};
        job.np  = 2'd1;
      end else if (base == ittf_pkg::BASE_16 &&
                   (in_mode == ittf_pkg::MODE_P || !mag_zero)) begin
        job.pre = {ittf_pkg::CH_ZERO, job.ucase ? ittf_pkg::CH_X_UP : ittf_pkg::CH_X_LO};
        job.np  = 2'd2;
      end
    end
  end

  ittf_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .mag    (mag),
    .base   (base),
    .pop    (pop),
    .status (conv_st)
  );

  ittf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .job       (job),
    .conv_st   (conv_st),
    .pop       (pop),
    .idle      (emit_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  assign in_ready = emit_idle;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("formatter ready right after taking an item");

  a_no_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pop)
    else $error("digit popped while idle");

  a_pop_settled: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> conv_st.done)
    else $error("digit popped before conversion finished");

endmodule

// ===== test/integer_to_text_formatter_test.sv =====
// Self-checking test of integer_to_text_formatter: random and directed numbers in,
// predicted ASCII text compared character by character. Depends on ittf_pkg and the RTL.
typedef struct packed {
  logic [7:0] ch;
  logic       last;
} text_char_t;

class text_scoreboard;
  localparam int WIDTH_CAP = 64;
  text_char_t expected_text[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function int pending();
    return expected_text.size();
  endfunction

  function void note_number(input logic [63:0] value, input logic [2:0] mode,
                            input logic wide, input logic alt, input logic zpad,
                            input logic lal, input logic [1:0] sm, input logic [6:0] fw);
    logic [63:0] v;
    logic [63:0] mag;
    logic [63:0] base;
    logic [7:0] pre[3];
    logic [7:0] dig[24];
    logic [7:0] text[$];
    logic [3:0] d;
    logic ucase;
    int np, nd, len, pad, w, i;
    text_char_t tc;
    np = 0;
    nd = 0;
    if (mode > ittf_pkg::MODE_P) return;
    w = (fw > WIDTH_CAP) ? WIDTH_CAP : int'(fw);
    ucase = (mode == ittf_pkg::MODE_X_UP);
    if (mode == ittf_pkg::MODE_O) base = 8;
    else if (mode == ittf_pkg::MODE_D || mode == ittf_pkg::MODE_U) base = 10;
    else base = 16;
    v = value;
    if (mode == ittf_pkg::MODE_D) begin
      if (!wide) v = {{32{value[31]}}, value[31:0]};
      mag = v[63] ? (64'd0 - v) : v;
      if (v[63]) begin
        pre[np] = ittf_pkg::CH_MINUS; np++;
      end else if (sm == ittf_pkg::SIGN_PLUS) begin
        pre[np] = ittf_pkg::CH_PLUS; np++;
      end else if (sm == ittf_pkg::SIGN_SPACE) begin
        pre[np] = ittf_pkg::CH_SPACE; np++;
      end
    end else begin
      mag = wide ? v : {32'd0, v[31:0]};
      if (mode == ittf_pkg::MODE_P || alt) begin
        if (base == 8 && mag != 0) begin
          pre[np] = ittf_pkg::CH_ZERO; np++;
        end else if (base == 16 && (mode == ittf_pkg::MODE_P || mag != 0)) begin
          pre[np] = ittf_pkg::CH_ZERO; np++;
          pre[np] = ucase ? ittf_pkg::CH_X_UP : ittf_pkg::CH_X_LO; np++;
        end
      end
    end
    do begin
      d = 4'(mag % base);
      mag = mag / base;
      dig[nd] = (d < 10) ? ittf_pkg::CH_ZERO + 8'(d)
                         : (ucase ? ittf_pkg::CH_A_UP : ittf_pkg::CH_A_LO) + 8'(d) - 8'd10;
      nd++;
    end while (mag != 0 && nd < 24);
    len = np + nd;
    pad = (w > len) ? w - len : 0;
    if (!lal && !zpad) for (i = 0; i < pad; i++) text.push_back(ittf_pkg::CH_SPACE);
    for (i = 0; i < np; i++) text.push_back(pre[i]);
    if (!lal && zpad) for (i = 0; i < pad; i++) text.push_back(ittf_pkg::CH_ZERO);
    for (i = nd; i > 0; i--) text.push_back(dig[i-1]);
    if (lal) for (i = 0; i < pad; i++) text.push_back(ittf_pkg::CH_SPACE);
    for (i = 0; i < text.size(); i++) begin
      tc.ch = text[i];
      tc.last = (i == text.size() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  function void check_char(input logic [7:0] ch, input logic last);
    text_char_t exp_c;
    if (expected_text.size() == 0) begin
      $error("unexpected item: out_char %h out_last %b", ch, last);
      errors++;
      return;
    end
    exp_c = expected_text.pop_front();
    if (ch !== exp_c.ch) begin
      $error("out_char expected %h actual %h", exp_c.ch, ch);
      errors++;
    end
    if (last !== exp_c.last) begin
      $error("out_last expected %b actual %b", exp_c.last, last);
      errors++;
    end
  endfunction
endclass

module integer_to_text_formatter_test;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 136;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_value = '0;
  logic [2:0]  in_mode = '0;
  logic        in_wide64 = 1'b0;
  logic        in_alt_form = 1'b0;
  logic        in_zero_pad = 1'b0;
  logic        in_left_align = 1'b0;
  logic [1:0]  in_sign_mode = '0;
  logic [6:0]  in_field_width = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic        out_last;

  text_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int stall_style = 0;
  int stall_count = 0;

  integer_to_text_formatter dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_mode       (in_mode),
    .in_wide64     (in_wide64),
    .in_alt_form   (in_alt_form),
    .in_zero_pad   (in_zero_pad),
    .in_left_align (in_left_align),
    .in_sign_mode  (in_sign_mode),
    .in_field_width(in_field_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last      (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[integer_to_text_formatter] ERROR");
      $finish;
    end
  end

  // receiver stall pattern, style chosen anew each time the stall counter runs out
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_count <= 96;
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= (stall_count % 4 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_char(out_char, out_last);
  end

  task automatic send_number(input logic [63:0] value, input logic [2:0] mode,
                             input logic wide, input logic alt, input logic zpad,
                             input logic lal, input logic [1:0] sm, input logic [6:0] fw);
    int gap;
    in_valid       <= 1'b1;
    in_value       <= value;
    in_mode        <= mode;
    in_wide64      <= wide;
    in_alt_form    <= alt;
    in_zero_pad    <= zpad;
    in_left_align  <= lal;
    in_sign_mode   <= sm;
    in_field_width <= fw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_number(value, mode, wide, alt, zpad, lal, sm, fw);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 6))
      0: return 64'($urandom_range(0, 999));
      1: return {{32{1'b0}}, $urandom};
      2: return {{32{1'b1}}, $urandom};
      3: return 64'h8000_0000_0000_0000 ^ 64'($urandom_range(0, 1));
      4: return 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 1));
      5: return {$urandom_range(0, 1) ? 32'hffff_ffff : 32'd0, 32'h8000_0000};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic directed_numbers();
    send_number(64'd0, ittf_pkg::MODE_D, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 7'd0);
    send_number(64'h8000_0000_0000_0000, ittf_pkg::MODE_D, 1'b1, 1'b0, 1'b0, 1'b0,
                2'd0, 7'd0);
    send_number(64'h7fff_ffff_ffff_ffff, ittf_pkg::MODE_D, 1'b1, 1'b0, 1'b0, 1'b0,
                ittf_pkg::SIGN_PLUS, 7'd0);
    send_number(64'h0000_0000_ffff_ffff, ittf_pkg::MODE_D, 1'b0, 1'b0, 1'b0, 1'b0,
                ittf_pkg::SIGN_PLUS, 7'd5);
    send_number(64'h1234_5678_8000_0000, ittf_pkg::MODE_D, 1'b0, 1'b0, 1'b1, 1'b0,
                2'd0, 7'd16);
    send_number(64'd42, ittf_pkg::MODE_D, 1'b0, 1'b1, 1'b0, 1'b0, ittf_pkg::SIGN_SPACE, 7'd0);
    send_number(64'd42, ittf_pkg::MODE_D, 1'b0, 1'b0, 1'b0, 1'b0, 2'd3, 7'd4);
    send_number(64'd0, ittf_pkg::MODE_O, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 7'd0);
    send_number(64'o777, ittf_pkg::MODE_O, 1'b0, 1'b1, 1'b0, 1'b0, ittf_pkg::SIGN_PLUS, 7'd0);
    send_number(64'hffff_ffff_ffff_ffff, ittf_pkg::MODE_O, 1'b1, 1'b1, 1'b0, 1'b0,
                2'd0, 7'd0);
    send_number(64'hffff_ffff_ffff_ffff, ittf_pkg::MODE_U, 1'b1, 1'b1, 1'b0, 1'b0,
                ittf_pkg::SIGN_PLUS, 7'd0);
    send_number(64'hffff_ffff_ffff_ffff, ittf_pkg::MODE_U, 1'b0, 1'b0, 1'b0, 1'b0,
                2'd0, 7'd0);
    send_number(64'd0, ittf_pkg::MODE_X_LO, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0, 7'd3);
    send_number(64'hdead_beef_cafe_f00d, ittf_pkg::MODE_X_LO, 1'b1, 1'b1, 1'b1, 1'b0,
                2'd0, 7'd24);
    send_number(64'hdead_beef_cafe_f00d, ittf_pkg::MODE_X_UP, 1'b0, 1'b1, 1'b0, 1'b1,
                2'd0, 7'd14);
    send_number(64'd0, ittf_pkg::MODE_P, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 7'd0);
    send_number(64'hffff_ffff_ffff_ffff, ittf_pkg::MODE_P, 1'b1, 1'b0, 1'b1, 1'b0,
                2'd0, 7'd20);
    send_number(64'd7, 3'd6, 1'b1, 1'b1, 1'b1, 1'b0, 2'd0, 7'd10);
    send_number(64'd7, 3'd7, 1'b0, 1'b0, 1'b0, 1'b1, ittf_pkg::SIGN_PLUS, 7'd127);
    send_number(64'hffff_ffff_ffff_fffb, ittf_pkg::MODE_D, 1'b1, 1'b0, 1'b1, 1'b0,
                2'd0, 7'd64);
    send_number(64'd12345, ittf_pkg::MODE_D, 1'b0, 1'b0, 1'b0, 1'b0,
                ittf_pkg::SIGN_PLUS, 7'd64);
    send_number(64'd12345, ittf_pkg::MODE_D, 1'b0, 1'b0, 1'b1, 1'b1,
                ittf_pkg::SIGN_SPACE, 7'd127);
    send_number(64'h00ab, ittf_pkg::MODE_X_UP, 1'b0, 1'b1, 1'b1, 1'b0, 2'd0, 7'd65);
    send_number(64'd99, ittf_pkg::MODE_U, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 7'd1);
  endtask

  initial begin
    int n;
    int m;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_numbers();
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      m = $urandom_range(0, 15);
      send_number(rand_value(), (m < 14) ? 3'(m % 6) : 3'(m - 8),
                  1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom_range(0, 3) == 0),
                  2'($urandom),
                  ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 24)));
    end
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[integer_to_text_formatter] OK");
    end else begin
      $display("[integer_to_text_formatter] ERROR");
    end
    $finish;
  end
endmodule
